/* sv/olpe_pkg.sv */
package olpe_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned IDX_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_PUSH_TAIL = 3'd2,
        OP_INSERT_AT = 3'd3,
        OP_POP_HEAD  = 3'd4,
        OP_POP_TAIL  = 3'd5,
        OP_REMOVE_AT = 3'd6,
        OP_DUMP      = 3'd7
    } op_t;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tail;
    } cell_cmd_t;

endpackage

/* sv/olpe_if.sv */
interface olpe_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [olpe_pkg::OP_W-1:0]             operation;
    logic signed [olpe_pkg::VALUE_W-1:0]   value;
    logic [olpe_pkg::POS_W-1:0]            position;

    modport source (output valid, operation, value, position, input ready);
    modport sink   (input valid, operation, value, position, output ready);
endinterface

interface olpe_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [olpe_pkg::STAT_W-1:0]           status;
    logic signed [olpe_pkg::VALUE_W-1:0]   data;
    logic [olpe_pkg::COUNT_W-1:0]          count;
    logic                                  last;

    modport source (output valid, status, data, count, last, input ready);
    modport sink   (input valid, status, data, count, last, output ready);
endinterface

/* sv/olpe_cell.sv */
module olpe_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                        clk,
    input  olpe_pkg::cell_cmd_t         cmd,
    input  logic [olpe_pkg::VALUE_W-1:0] ins_value,
    input  logic [olpe_pkg::VALUE_W-1:0] left,
    input  logic [olpe_pkg::VALUE_W-1:0] right,
    input  logic [olpe_pkg::VALUE_W-1:0] head,
    output logic [olpe_pkg::VALUE_W-1:0] q
);
    import olpe_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (MY_IDX == cmd.idx)
                    entry_next = ins_value;
                else if (MY_IDX > cmd.idx)
                    entry_next = left;
            end
            CELL_REM:
            begin
                if (MY_IDX >= cmd.idx)
                    entry_next = right;
            end
            CELL_ROT:
            begin
                if (MY_IDX == cmd.tail)
                    entry_next = head;
                else
                    entry_next = right;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

/* sv/ordered_list_positional_engine.sv */
// Channel | Dir | Payload                          | Beat
// req     | in  | operation, value, position       | one operation
// rsp     | out | status, data, count, last        | one result
//
// Every operation but dump gives one beat; req is taken again
// as soon as the rsp register is free or being drained.
// A dump of a non-empty list enters the dump state, then gives one beat per entry:
// the cell row rotates by one each beat, so length beats restore the order.
// req stays low for the whole dump. rsp backpressure stalls the rotation.
// Reset clears length and handshake state; entry contents are undefined until written.
module ordered_list_positional_engine #(
    parameter int unsigned CAPACITY = 32
) (
    input logic          clk,
    input logic          rst_n,
    olpe_req_if.sink     req,
    olpe_rsp_if.source   rsp
);
    import olpe_pkg::*;

    localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   dcnt_reg, dcnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    logic [VALUE_W-1:0] cell_q [CAPACITY];
    cell_cmd_t          cmd_c, cmd_eff;

    logic               in_fire, step_free, full, empty, pos_ok, dump_last;
    logic [CMP_W-1:0]   len_c, pos_c;
    logic [IDX_W-1:0]   len_idx, tail_idx, pos_idx, rem_idx;
    logic [VALUE_W-1:0] sel_data;
    logic [LEN_W-1:0]   op_len;
    logic [STAT_W-1:0]  op_status;
    logic [VALUE_W-1:0] op_data;
    logic               op_dump;

    assign step_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_RUN) && step_free;
    assign in_fire   = req.valid && req.ready;

    assign len_c    = CMP_W'(len_reg);
    assign pos_c    = CMP_W'(req.position);
    assign full     = (len_reg >= LEN_W'(CAPACITY));
    assign empty    = (len_reg == '0);
    assign pos_ok   = (pos_c != '0) && (pos_c <= len_c);
    assign len_idx  = IDX_W'(len_reg);
    assign tail_idx = IDX_W'(len_reg - LEN_W'(1));
    assign pos_idx  = IDX_W'(req.position - POS_W'(1));
    assign dump_last = (dcnt_reg == len_reg - LEN_W'(1));

    assign rem_idx = (req.operation == OP_POP_HEAD) ? '0 :
                     (req.operation == OP_POP_TAIL) ? tail_idx : pos_idx;

    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rem_idx == IDX_W'(i))
                sel_data = cell_q[i];
        end
    end

    always_comb
    begin
        cmd_c.op   = CELL_HOLD;
        cmd_c.idx  = '0;
        cmd_c.tail = tail_idx;
        op_len     = len_reg;
        op_status  = ST_OK;
        op_data    = '0;
        op_dump    = 1'b0;
        case (req.operation)
            OP_CLEAR:
                op_len = '0;
            OP_PUSH_HEAD, OP_PUSH_TAIL:
            begin
                if (full)
                    op_status = ST_FULL;
                else
                begin
                    cmd_c.op  = CELL_INS;
                    cmd_c.idx = (req.operation == OP_PUSH_HEAD) ? '0 : len_idx;
                    op_len    = len_reg + LEN_W'(1);
                end
            end
            OP_INSERT_AT:
            begin
                if (!pos_ok)
                    op_status = ST_BADPOS;
                else if (full)
                    op_status = ST_FULL;
                else
                begin
                    cmd_c.op  = CELL_INS;
                    cmd_c.idx = pos_idx;
                    op_len    = len_reg + LEN_W'(1);
                end
            end
            OP_POP_HEAD, OP_POP_TAIL:
            begin
                if (empty)
                    op_status = ST_EMPTY;
                else
                begin
                    cmd_c.op  = CELL_REM;
                    cmd_c.idx = (req.operation == OP_POP_HEAD) ? '0 : tail_idx;
                    op_data   = sel_data;
                    op_len    = len_reg - LEN_W'(1);
                end
            end
            OP_REMOVE_AT:
            begin
                if (empty)
                    op_status = ST_EMPTY;
                else if (!pos_ok)
                    op_status = ST_BADPOS;
                else
                begin
                    cmd_c.op  = CELL_REM;
                    cmd_c.idx = pos_idx;
                    op_data   = sel_data;
                    op_len    = len_reg - LEN_W'(1);
                end
            end
            OP_DUMP:
            begin
                if (empty)
                    op_status = ST_EMPTY;
                else
                    op_dump = 1'b1;
            end
            default:
                op_len = len_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        dcnt_next       = dcnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        cmd_eff.op      = CELL_HOLD;
        cmd_eff.idx     = cmd_c.idx;
        cmd_eff.tail    = tail_idx;
        case (state_reg)
            S_RUN:
            begin
                if (in_fire)
                begin
                    cmd_eff  = cmd_c;
                    len_next = op_len;
                    if (op_dump)
                    begin
                        state_next = S_DUMP;
                        dcnt_next  = '0;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = op_status;
                        out_data_next   = op_data;
                        out_count_next  = COUNT_W'(op_len);
                        out_last_next   = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (step_free)
                begin
                    cmd_eff.op      = CELL_ROT;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = cell_q[0];
                    out_count_next  = COUNT_W'(len_reg);
                    out_last_next   = dump_last;
                    dcnt_next       = dcnt_reg + LEN_W'(1);
                    if (dump_last)
                        state_next = S_RUN;
                end
            end
            default:
                state_next = S_RUN;
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        olpe_cell #(
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd_eff),
            .ins_value (req.value),
            .left      ((g == 0) ? req.value : cell_q[(g == 0) ? 0 : g - 1]),
            .right     ((g == CAPACITY - 1) ? cell_q[g]
                                            : cell_q[(g == CAPACITY - 1) ? g : g + 1]),
            .head      (cell_q[0]),
            .q         (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            len_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.count  = out_count_reg;
    assign rsp.last   = out_last_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("length above capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (len_reg != '0) && (dcnt_reg < len_reg))
        else $error("dump running on bad length or count");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !op_dump) |=> out_valid_reg && out_last_reg)
        else $error("operation gave no final beat");

    a_dump_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(len_reg))
        else $error("length changed during dump");
`endif

endmodule

/* bench/tb_ordered_list_positional_engine.sv */
module tb_ordered_list_positional_engine;
    import olpe_pkg::*;

    localparam int unsigned LIST_DEPTH    = 32;
    localparam int unsigned RANDOM_ITEMS  = 390;
    localparam int unsigned IDLE_PCT      = 31;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned DIRECTED_ROWS = 21;

    typedef enum int {
        MODE_GROW   = 0,
        MODE_SHRINK = 1,
        MODE_MIXED  = 2
    } episode_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] data;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } list_result_t;

    typedef struct packed {
        bit           typed;
        list_result_t want;
    } item_note_t;

    typedef struct {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        bit                        typed;
        list_result_t              want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    olpe_req_if req_ch();
    olpe_rsp_if rsp_ch();

    ordered_list_positional_engine #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int unsigned               shadow_len = 0;
    list_result_t              expected_results [$];
    item_note_t                item_notes [$];

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_DUMP,      32'sd0,         6'd0,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}},
        '{OP_POP_HEAD,  32'sd0,         6'd0,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}},
        '{OP_POP_TAIL,  32'sd0,         6'd0,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}},
        '{OP_REMOVE_AT, 32'sd0,         6'd1,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}},
        '{OP_REMOVE_AT, 32'sd0,         6'd0,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}},
        '{OP_INSERT_AT, 32'sd5,         6'd1,  1'b1, '{ST_BADPOS, 32'sd0, 6'd0, 1'b1}},
        '{OP_PUSH_HEAD, 32'h7FFF_FFFF,  6'd0,  1'b1, '{ST_OK,     32'sd0, 6'd1, 1'b1}},
        '{OP_PUSH_TAIL, 32'h8000_0000,  6'd0,  1'b1, '{ST_OK,     32'sd0, 6'd2, 1'b1}},
        '{OP_INSERT_AT, 32'sd9,         6'd0,  1'b1, '{ST_BADPOS, 32'sd0, 6'd2, 1'b1}},
        '{OP_INSERT_AT, 32'sd9,         6'd3,  1'b1, '{ST_BADPOS, 32'sd0, 6'd2, 1'b1}},
        '{OP_INSERT_AT, 32'hFFFF_FFFF,  6'd2,  1'b0, '0},
        '{OP_INSERT_AT, 32'sd0,         6'd1,  1'b0, '0},
        '{OP_DUMP,      32'sd0,         6'd0,  1'b0, '0},
        '{OP_REMOVE_AT, 32'sd0,         6'd63, 1'b1, '{ST_BADPOS, 32'sd0, 6'd4, 1'b1}},
        '{OP_REMOVE_AT, 32'sd0,         6'd0,  1'b1, '{ST_BADPOS, 32'sd0, 6'd4, 1'b1}},
        '{OP_REMOVE_AT, 32'sd0,         6'd2,  1'b0, '0},
        '{OP_POP_HEAD,  32'sd0,         6'd0,  1'b0, '0},
        '{OP_POP_TAIL,  32'sd0,         6'd0,  1'b0, '0},
        '{OP_DUMP,      32'sd0,         6'd0,  1'b0, '0},
        '{OP_CLEAR,     32'sd0,         6'd0,  1'b1, '{ST_OK,     32'sd0, 6'd0, 1'b1}},
        '{OP_DUMP,      32'sd0,         6'd0,  1'b1, '{ST_EMPTY,  32'sd0, 6'd0, 1'b1}}
    };

    // per-operation weights, summed in order: clear, push head, push tail, insert, pop head, pop tail, remove, dump
    int unsigned op_weights [3][8] = '{
        '{0, 30, 25, 25,  5,  5,  5,  5},
        '{0,  8,  8,  8, 20, 20, 26, 10},
        '{2, 15, 15, 18, 12, 12, 16, 10}
    };

    function automatic void insert_entry(int unsigned idx, logic signed [VALUE_W-1:0] value);
        for (int unsigned i = shadow_len; i > idx; i--)
            shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[idx] = value;
        shadow_len++;
    endfunction

    function automatic logic signed [VALUE_W-1:0] extract_entry(int unsigned idx);
        logic signed [VALUE_W-1:0] taken;
        taken = shadow_entries[idx];
        for (int unsigned i = idx; i + 1 < shadow_len; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_len--;
        return taken;
    endfunction

    function automatic void apply_list_op(input op_t op, input logic signed [VALUE_W-1:0] value,
                                          input logic [POS_W-1:0] position,
                                          ref list_result_t outq [$]);
        list_result_t r;
        int unsigned  pos;
        pos = position;
        r = list_result_t'{ST_OK, '0, '0, 1'b1};
        case (op)
            OP_CLEAR:
                shadow_len = 0;
            OP_PUSH_HEAD, OP_PUSH_TAIL:
                if (shadow_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                    insert_entry(op == OP_PUSH_HEAD ? 0 : shadow_len, value);
            OP_INSERT_AT:
                if (pos < 1 || pos > shadow_len)
                    r.status = ST_BADPOS;
                else if (shadow_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                    insert_entry(pos - 1, value);
            OP_POP_HEAD, OP_POP_TAIL:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = extract_entry(op == OP_POP_HEAD ? 0 : shadow_len - 1);
            OP_REMOVE_AT:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (pos < 1 || pos > shadow_len)
                    r.status = ST_BADPOS;
                else
                    r.data = extract_entry(pos - 1);
            default:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (int unsigned i = 0; i < shadow_len; i++)
                        outq.push_back(list_result_t'{ST_OK, shadow_entries[i],
                                                      COUNT_W'(shadow_len),
                                                      i + 1 == shadow_len});
                    return;
                end
        endcase
        r.count = COUNT_W'(shadow_len);
        outq.push_back(r);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic drive_item(input op_t op, input logic signed [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] position, input bit typed,
                              input list_result_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_notes.push_back(item_note_t'{typed, want});
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= value;
        req_ch.position  <= position;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        list_result_t predicted [$];
        item_note_t   note;
        bit           moved;
        moved = 1'b0;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            moved = 1'b1;
            got = list_result_t'{rsp_ch.status, rsp_ch.data, rsp_ch.count, rsp_ch.last};
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("result beat with nothing expected: status %0d data %0d",
                                        got.status, got.data));
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.data !== want.data)
                    flag_mismatch($sformatf("data %0d, expected %0d", got.data, want.data));
                if (got.count !== want.count)
                    flag_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            moved = 1'b1;
            predicted = {};
            apply_list_op(op_t'(req_ch.operation), req_ch.value, req_ch.position, predicted);
            note = item_notes.pop_front();
            if (note.typed)
                expected_results.push_back(note.want);
            else
                foreach (predicted[i])
                    expected_results.push_back(predicted[i]);
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        episode_t                  mode;
        int unsigned               plan_len;
        int unsigned               run_left;
        int unsigned               roll;
        int unsigned               acc;
        int unsigned               pick;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_CLEAR;
        req_ch.value     = '0;
        req_ch.position  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].position,
                       directed_rows[i].typed, directed_rows[i].want);

        // open with a long growth run so the full list is reached early
        plan_len = 0;
        mode     = MODE_GROW;
        run_left = 60;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (run_left == 0)
            begin
                mode     = episode_t'($urandom_range(0, 2));
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            steady <= (n >= 120 && n < 200);

            roll = $urandom_range(0, 99);
            acc  = 0;
            op   = OP_DUMP;
            for (int k = 0; k < 8; k++)
            begin
                acc += op_weights[mode][k];
                if (roll < acc)
                begin
                    op = op_t'(k);
                    break;
                end
            end

            value = $urandom();
            pick  = $urandom_range(0, 9);
            if (pick == 0)
                position = POS_W'($urandom_range(0, 63));
            else if (pick == 1)
                position = POS_W'(plan_len + $urandom_range(0, 1));
            else if (plan_len == 0)
                position = POS_W'($urandom_range(0, 2));
            else
                position = POS_W'($urandom_range(1, plan_len));

            case (op)
                OP_CLEAR:
                    plan_len = 0;
                OP_PUSH_HEAD, OP_PUSH_TAIL:
                    if (plan_len < LIST_DEPTH)
                        plan_len++;
                OP_INSERT_AT:
                    if (position >= 1 && position <= plan_len && plan_len < LIST_DEPTH)
                        plan_len++;
                OP_POP_HEAD, OP_POP_TAIL:
                    if (plan_len > 0)
                        plan_len--;
                OP_REMOVE_AT:
                    if (position >= 1 && position <= plan_len)
                        plan_len--;
                default: ;
            endcase

            drive_item(op, value, position, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        steady       <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/olpe_pkg.sv
sv/olpe_if.sv
sv/olpe_cell.sv
sv/ordered_list_positional_engine.sv
bench/tb_ordered_list_positional_engine.sv
